// ===== rtl/core/pru_pkg.sv =====
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants of the pixel replication upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

	localparam int CHAN_W      = 8;
	localparam int PAD_W       = 2;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;
	localparam int SCALE_REG_W = 5;
	localparam int WIDTH_REG_W = 11;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [SCALE_REG_W-1:0] SCALE_RESET = SCALE_REG_W'(1);
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = WIDTH_REG_W'(1);

	// Register index, taken from paddr[2].
	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_WIDTH = 1'b1;

	// Input command codes.
	localparam logic CMD_PIXEL  = 1'b0;
	localparam logic CMD_REPLAY = 1'b1;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

endpackage

// ===== rtl/core/pru_front.sv =====
// ----------------------------------------------------------------------------
// pru_front
// Configuration registers, input acceptance and command classification.
// Tracks the row position and pending replays and queues work entries.
// ----------------------------------------------------------------------------
module pru_front #(
	parameter int MAX_ROW_WIDTH = 1024,
	parameter int MAX_SCALE     = 16,
	parameter int EW            = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pru_pkg::APB_AW-1:0]          paddr,
	input  logic [pru_pkg::APB_DW-1:0]          pwdata,
	output logic [pru_pkg::APB_DW-1:0]          prdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic [pru_pkg::CHAN_W-1:0]          in_blue,
	input  logic [pru_pkg::CHAN_W-1:0]          in_green,
	input  logic [pru_pkg::CHAN_W-1:0]          in_red,
	output logic                                q_push,
	output logic [EW-1:0]                       q_data,
	input  logic                                q_full
);

	localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
	localparam int WW = $clog2(MAX_ROW_WIDTH + 1);
	localparam int SW = $clog2(MAX_SCALE + 1);
	localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int PW = (MAX_ROW_WIDTH * MAX_SCALE > 1) ?
		$clog2(MAX_ROW_WIDTH * MAX_SCALE) : 1;
	localparam int LW = $clog2(MAX_ROW_WIDTH * MAX_SCALE + 1);

	typedef struct packed {
		logic                        is_pix;
		logic                        div_en;
		logic                        row_end;
		logic [pru_pkg::PAD_W-1:0]   pad;
		logic [SW-1:0]               scale;
		logic [AW-1:0]               addr;
		logic [PW-1:0]               pos;
		pru_pkg::pixel_t             pix;
	} entry_t;

	logic [pru_pkg::SCALE_REG_W-1:0] scale_q;
	logic [pru_pkg::WIDTH_REG_W-1:0] width_q;
	logic [AW-1:0]                   col_q;
	logic [RW-1:0]                   rep_q;
	logic [PW-1:0]                   pos_q;

	logic [SW-1:0]             eff_s;
	logic [WW-1:0]             eff_w;
	logic [WW-1:0]             wm1;
	logic [LW-1:0]             out_len;
	logic [pru_pkg::PAD_W-1:0] pad;
	logic                      pix_end;
	logic                      rep_end;
	logic                      take;
	logic                      cfg_wr;
	entry_t                    ent;

	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= pru_pkg::SCALE_RESET;
			width_q <= pru_pkg::WIDTH_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				pru_pkg::REG_SCALE: scale_q <= pwdata[pru_pkg::SCALE_REG_W-1:0];
				pru_pkg::REG_WIDTH: width_q <= pwdata[pru_pkg::WIDTH_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pru_pkg::REG_SCALE: prdata = pru_pkg::APB_DW'(scale_q);
			pru_pkg::REG_WIDTH: prdata = pru_pkg::APB_DW'(width_q);
			default:            prdata = '0;
		endcase
	end

	always_comb begin
		if (scale_q == '0) begin
			eff_s = SW'(1);
		end else if (32'(scale_q) > MAX_SCALE) begin
			eff_s = SW'(MAX_SCALE);
		end else begin
			eff_s = SW'(scale_q);
		end
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(width_q) > MAX_ROW_WIDTH) begin
			eff_w = WW'(MAX_ROW_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
	end

	assign wm1     = eff_w - WW'(1);
	assign out_len = LW'(LW'(eff_w) * LW'(eff_s));
	// Padding to a multiple of four bytes for 3-byte pixels is the length mod 4.
	assign pad     = pru_pkg::PAD_W'(out_len);
	assign pix_end = WW'(col_q) >= wm1;
	assign rep_end = LW'(pos_q) >= (out_len - LW'(1));

	always_comb begin
		ent       = '0;
		ent.scale = eff_s;
		if (cmd == pru_pkg::CMD_PIXEL) begin
			take            = (rep_q == '0);
			ent.is_pix      = 1'b1;
			ent.row_end     = pix_end;
			ent.pad         = pix_end ? pad : '0;
			ent.addr        = col_q;
			ent.pix.red     = in_red;
			ent.pix.green   = in_green;
			ent.pix.blue    = in_blue;
		end else begin
			take        = (rep_q != '0);
			ent.div_en  = !rep_end;
			ent.row_end = rep_end;
			ent.pad     = rep_end ? pad : '0;
			ent.addr    = rep_end ? AW'(wm1) : '0;
			ent.pos     = pos_q;
		end
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready && take;
	assign q_data   = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			rep_q <= '0;
			pos_q <= '0;
		end else if (q_push) begin
			if (cmd == pru_pkg::CMD_PIXEL) begin
				if (pix_end) begin
					col_q <= '0;
					rep_q <= RW'(eff_s - SW'(1));
					pos_q <= '0;
				end else begin
					col_q <= col_q + AW'(1);
				end
			end else begin
				if (rep_end) begin
					pos_q <= '0;
					rep_q <= rep_q - RW'(1);
				end else begin
					pos_q <= pos_q + PW'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/core/pru_queue.sv =====
// ----------------------------------------------------------------------------
// pru_queue
// Small first-in first-out queue of work entries between front and back.
// ----------------------------------------------------------------------------
module pru_queue #(
	parameter int W     = 64,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (cnt_q == CNTW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/pru_back.sv =====
// ----------------------------------------------------------------------------
// pru_back
// Executes queued entries: a pipelined restoring divider maps the replay
// position to a source column, the line store is written or read, and an
// expander drives the result register with the copies of each pixel.
// ----------------------------------------------------------------------------
module pru_back #(
	parameter int MAX_ROW_WIDTH = 1024,
	parameter int MAX_SCALE     = 16,
	parameter int EW            = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  logic [EW-1:0]                q_data,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pru_pkg::CHAN_W-1:0]   out_blue,
	output logic [pru_pkg::CHAN_W-1:0]   out_green,
	output logic [pru_pkg::CHAN_W-1:0]   out_red,
	output logic                         row_end,
	output logic [pru_pkg::PAD_W-1:0]    pad_bytes,
	output logic                         last_of_run
);

	localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
	localparam int SW = $clog2(MAX_SCALE + 1);
	localparam int PW = (MAX_ROW_WIDTH * MAX_SCALE > 1) ?
		$clog2(MAX_ROW_WIDTH * MAX_SCALE) : 1;
	localparam int DW = SW + AW;

	typedef struct packed {
		logic                        is_pix;
		logic                        div_en;
		logic                        row_end;
		logic [pru_pkg::PAD_W-1:0]   pad;
		logic [SW-1:0]               scale;
		logic [AW-1:0]               addr;
		logic [PW-1:0]               pos;
		pru_pkg::pixel_t             pix;
	} entry_t;

	entry_t          st_q  [AW+1];
	entry_t          nxt   [AW];
	logic [AW:0]     vld_q;
	pru_pkg::pixel_t mem   [MAX_ROW_WIDTH];
	pru_pkg::pixel_t rdata_q;
	entry_t          r_q;
	logic            r_vld_q;
	logic [SW-1:0]   cnt_q;
	logic            out_vld_q;
	pru_pkg::pixel_t r_pix;
	logic            emit;
	logic            last_copy;
	logic            adv;

	// One quotient bit per stage, most significant first.
	always_comb begin
		logic [DW-1:0] dsh;
		dsh = '0;
		for (int j = 0; j < AW; j++) begin
			nxt[j] = st_q[j];
			dsh    = DW'(st_q[j].scale) << (AW - 1 - j);
			if (st_q[j].div_en && (DW'(st_q[j].pos) >= dsh)) begin
				nxt[j].pos            = PW'(DW'(st_q[j].pos) - dsh);
				nxt[j].addr[AW-1-j]   = 1'b1;
			end
		end
	end

	assign r_pix     = r_q.is_pix ? r_q.pix : rdata_q;
	assign emit      = r_vld_q && (!out_vld_q || out_ready);
	assign last_copy = !r_q.is_pix || (cnt_q == (r_q.scale - SW'(1)));
	assign adv       = !r_vld_q || (emit && last_copy);
	assign q_pop     = adv && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			r_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q   <= {vld_q[AW-1:0], !q_empty};
			r_vld_q <= vld_q[AW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0] <= q_data;
			for (int j = 1; j <= AW; j++) begin
				st_q[j] <= nxt[j-1];
			end
			r_q <= st_q[AW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_q[AW]) begin
			if (st_q[AW].is_pix) begin
				mem[st_q[AW].addr] <= st_q[AW].pix;
			end else begin
				rdata_q <= mem[st_q[AW].addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				cnt_q     <= last_copy ? '0 : cnt_q + SW'(1);
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_blue    <= r_pix.blue;
			out_green   <= r_pix.green;
			out_red     <= r_pix.red;
			row_end     <= r_q.row_end && last_copy;
			pad_bytes   <= (r_q.row_end && last_copy) ? r_q.pad : '0;
			last_of_run <= last_copy;
		end
	end

	assign out_valid = out_vld_q;

endmodule

// ===== rtl/core/pixel_replication_upscaler.sv =====
// ----------------------------------------------------------------------------
// pixel_replication_upscaler
// Integer nearest-neighbor upscaler for 24-bit pixel rows.
//
//   Channel  Handshake                  Beat contents
//   in       in_valid / in_ready        cmd, in_blue, in_green, in_red
//   out      out_valid / out_ready      out_blue, out_green, out_red,
//                                       row_end, pad_bytes, last_of_run
//   config   APB psel/penable, pready   scale_factor at 0, input_row_width at 4
//
// The result register gives one beat per cycle while the output is not stalled:
// a pixel beat yields scale output beats, a replay beat one. Input beats are taken
// at one per cycle while the four-entry queue has room. An input beat passes
// through the queue, the divider pipeline and the result register to the output.
// Reset sets scale and width to 1 and clears the row state, but not the line store.
// A stalled output holds the back end, and the front stalls when the queue fills.
// ----------------------------------------------------------------------------
module pixel_replication_upscaler #(
	parameter int MAX_ROW_WIDTH = 1024,
	parameter int MAX_SCALE     = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pru_pkg::APB_AW-1:0]   paddr,
	input  logic [pru_pkg::APB_DW-1:0]   pwdata,
	output logic [pru_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [pru_pkg::CHAN_W-1:0]   in_blue,
	input  logic [pru_pkg::CHAN_W-1:0]   in_green,
	input  logic [pru_pkg::CHAN_W-1:0]   in_red,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pru_pkg::CHAN_W-1:0]   out_blue,
	output logic [pru_pkg::CHAN_W-1:0]   out_green,
	output logic [pru_pkg::CHAN_W-1:0]   out_red,
	output logic                         row_end,
	output logic [pru_pkg::PAD_W-1:0]    pad_bytes,
	output logic                         last_of_run
);

	localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
	localparam int SW = $clog2(MAX_SCALE + 1);
	localparam int PW = (MAX_ROW_WIDTH * MAX_SCALE > 1) ?
		$clog2(MAX_ROW_WIDTH * MAX_SCALE) : 1;
	localparam int EW = 3 + pru_pkg::PAD_W + SW + AW + PW + $bits(pru_pkg::pixel_t);

	logic          q_push;
	logic [EW-1:0] q_wdata;
	logic          q_full;
	logic          q_pop;
	logic [EW-1:0] q_rdata;
	logic          q_empty;

	assign pready = 1'b1;

	pru_front #(
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH),
		.MAX_SCALE     (MAX_SCALE),
		.EW            (EW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.in_blue  (in_blue),
		.in_green (in_green),
		.in_red   (in_red),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.q_full   (q_full)
	);

	pru_queue #(
		.W     (EW),
		.DEPTH (pru_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	pru_back #(
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH),
		.MAX_SCALE     (MAX_SCALE),
		.EW            (EW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_blue    (out_blue),
		.out_green   (out_green),
		.out_red     (out_red),
		.row_end     (row_end),
		.pad_bytes   (pad_bytes),
		.last_of_run (last_of_run)
	);

endmodule
